FILE: src/vertex_attribute_to_float_assert.svh
// Assertion macros for the vertex attribute converter.
`ifndef VERTEX_ATTRIBUTE_TO_FLOAT_ASSERT_SVH
`define VERTEX_ATTRIBUTE_TO_FLOAT_ASSERT_SVH

// same-cycle implication
`define VATF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VATF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vatf_pkg.sv
// Shared types and constants of the vertex attribute converter.
package vatf_pkg;

    localparam logic [2:0] FMT_S8  = 3'd0;
    localparam logic [2:0] FMT_U8  = 3'd1;
    localparam logic [2:0] FMT_S16 = 3'd2;
    localparam logic [2:0] FMT_U16 = 3'd3;
    localparam logic [2:0] FMT_S32 = 3'd4;
    localparam logic [2:0] FMT_U32 = 3'd5;
    localparam logic [2:0] FMT_F32 = 3'd6;
    localparam logic [2:0] FMT_RSV = 3'd7;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_FORMAT = 1'b0;
    localparam t_cfg_idx CFG_NORM   = 1'b1;

    localparam logic [31:0] DIV_S8  = 32'd127;
    localparam logic [31:0] DIV_U8  = 32'd255;
    localparam logic [31:0] DIV_S16 = 32'd32767;
    localparam logic [31:0] DIV_U16 = 32'd65535;

    localparam logic [7:0] EXP_BIAS_M1 = 8'd126;
    localparam logic [7:0] EXP_ONE     = 8'd127;

    // unpacked word: value is 0.x * 2^e, sticky marks a nonzero tail past x
    typedef struct packed {
        logic        pass;
        logic        zero;
        logic        one;
        logic        neg;
        logic        sticky;
        logic [5:0]  e;
        logic [63:0] x;
        logic [31:0] raw;
    } t_stage1;

    typedef struct packed {
        logic        pass;
        logic [31:0] bits;
    } t_result;

endpackage

FILE: src/vatf_if.sv
// Stream interfaces for raw component words and binary32 result words.
interface vatf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_component;
    modport source (output valid, output raw_component, input ready);
    modport sink   (input valid, input raw_component, output ready);
endinterface

interface vatf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

FILE: src/vatf_fp_pack.sv
// Normalize, round to nearest even and pack stages (three register stages).
module vatf_fp_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  vatf_pkg::t_stage1 i_s,
    output logic              o_valid,
    output vatf_pkg::t_result o_res
);
    import vatf_pkg::*;

    logic    r_v2, r_v3, r_v4;
    t_stage1 r_s2, r_s3;
    logic [5:0] r_lz;
    logic [7:0] r_exp3;
    t_result r_res;

    logic [5:0] n_lz;
    logic       found;
    always_comb begin
        n_lz  = '0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && i_s.x[i]) begin
                found = 1'b1;
                n_lz  = 6'(63 - i);
            end
        end
    end

    t_stage1 n_s3;
    always_comb begin
        n_s3   = r_s2;
        n_s3.x = r_s2.x << r_lz;
    end

    logic [23:0] mant;
    logic        guard, stk, up;
    logic [24:0] sum;
    logic [7:0]  exp_f;
    logic [22:0] frac;
    t_result     n_res;
    always_comb begin
        mant  = r_s3.x[63:40];
        guard = r_s3.x[39];
        stk   = (|r_s3.x[38:0]) | r_s3.sticky;
        up    = guard & (stk | mant[0]);
        sum   = {1'b0, mant} + {24'd0, up};
        exp_f = r_exp3 + {7'd0, sum[24]};
        frac  = sum[24] ? 23'd0 : sum[22:0];
        n_res.pass = r_s3.pass;
        if (r_s3.pass)
            n_res.bits = r_s3.raw;
        else if (r_s3.zero)
            n_res.bits = '0;
        else if (r_s3.one)
            n_res.bits = {r_s3.neg, EXP_ONE, 23'd0};
        else
            n_res.bits = {r_s3.neg, exp_f, frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2   <= i_s;
            r_lz   <= n_lz;
            r_s3   <= n_s3;
            r_exp3 <= {2'd0, r_s2.e} + EXP_BIAS_M1 - {2'd0, r_lz};
            r_res  <= n_res;
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

endmodule

FILE: src/vertex_attribute_to_float.sv
// Top level: vertex attribute component word to IEEE binary32 converter.
//
//   channel   dir  payload                 notes
//   i_in      in   raw_component [31:0]    one word per item
//   o_out     out  float_bits    [31:0]    one word per input word
//   i_cfg_*   in   format / normalize      write only while idle
//
// Four register stages: unpack, leading-zero count, shift, round/pack.
// One word per cycle sustained while o_out is ready.
// A stall on o_out freezes every stage; nothing is dropped or repeated.
// Synchronous active-low reset empties the pipe and sets format float32,
// normalize off.
module vertex_attribute_to_float (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  vatf_pkg::t_cfg_idx i_cfg_idx,
    input  logic [2:0]         i_cfg_wdata,
    vatf_in_if.sink            i_in,
    vatf_out_if.source         o_out
);
    import vatf_pkg::*;

    `include "vertex_attribute_to_float_assert.svh"

    logic [2:0] r_fmt;
    logic       r_norm;
    logic       r_v1;
    t_stage1    r_s1, n_s1;
    logic       w_en;
    logic       w_v4;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_F32;
            r_norm <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FORMAT: r_fmt  <= i_cfg_wdata;
                CFG_NORM:   r_norm <= i_cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    assign w_en       = !w_v4 || o_out.ready;
    assign i_in.ready = w_en;

    logic [31:0] v, mask, mag, div;
    logic        sgn, neg, narrow;
    logic [69:0] rep7;
    logic [74:0] rep15;
    always_comb begin
        v      = '0;
        mask   = '1;
        sgn    = 1'b0;
        div    = DIV_U16;
        narrow = 1'b0;
        case (r_fmt) inside
            FMT_S8, FMT_U8: begin
                v      = {24'd0, i_in.raw_component[7:0]};
                mask   = 32'h0000_00FF;
                sgn    = i_in.raw_component[7];
                narrow = 1'b1;
            end
            FMT_S16, FMT_U16: begin
                v      = {16'd0, i_in.raw_component[15:0]};
                mask   = 32'h0000_FFFF;
                sgn    = i_in.raw_component[15];
                narrow = 1'b1;
            end
            default: begin
                v   = i_in.raw_component;
                sgn = i_in.raw_component[31];
            end
        endcase
        case (r_fmt)
            FMT_S8:  div = DIV_S8;
            FMT_U8:  div = DIV_U8;
            FMT_S16: div = DIV_S16;
            default: div = DIV_U16;
        endcase
        neg  = sgn && !r_fmt[0] && (r_fmt < FMT_F32);
        mag  = neg ? ((~v + 32'd1) & mask) : v;
        rep7  = {10{mag[6:0]}};
        rep15 = {5{mag[14:0]}};

        n_s1.pass   = (r_fmt == FMT_F32) || (r_fmt == FMT_RSV);
        n_s1.zero   = (mag == 32'd0);
        n_s1.neg    = neg;
        n_s1.raw    = i_in.raw_component;
        n_s1.one    = 1'b0;
        n_s1.sticky = 1'b0;
        n_s1.e      = 6'd32;
        n_s1.x      = {mag, 32'd0};
        if (r_norm && narrow) begin
            // m/(2^n-1) for m below the divisor is m repeated in n-bit blocks
            n_s1.one    = (mag >= div);
            n_s1.sticky = 1'b1;
            n_s1.e      = 6'd0;
            case (r_fmt)
                FMT_S8:  n_s1.x = rep7[69:6];
                FMT_U8:  n_s1.x = {8{mag[7:0]}};
                FMT_S16: n_s1.x = rep15[74:11];
                default: n_s1.x = {4{mag[15:0]}};
            endcase
        end else if (r_norm && r_fmt == FMT_S32) begin
            n_s1.e = 6'd1;      // divisor rounds to 2^31
        end else if (r_norm && r_fmt == FMT_U32) begin
            n_s1.e = 6'd0;      // divisor rounds to 2^32
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (w_en)
            r_v1 <= i_in.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en)
            r_s1 <= n_s1;
    end

    vatf_fp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v1),
        .i_s     (r_s1),
        .o_valid (w_v4),
        .o_res   (w_res)
    );

    assign o_out.valid      = w_v4;
    assign o_out.float_bits = w_res.bits;

    `VATF_ASSERT_IMP(a_no_inf_nan, o_out.valid && !w_res.pass, o_out.float_bits[30:23] != 8'hFF, "converted word has all-ones exponent")
    `VATF_ASSERT_IMP(a_nonzero_word, r_v1 && !r_s1.pass && !r_s1.zero && !r_s1.one, r_s1.x != 64'd0, "nonzero magnitude lost in unpack")
    `VATF_ASSERT_IMP(a_one_not_zero, r_v1 && r_s1.one, !r_s1.zero, "unit and zero flags both set")
    `VATF_ASSERT_NXT(a_stall_holds, r_v1 && !w_en, r_v1 && $stable(r_s1), "stage one changed under stall")

endmodule

FILE: dv/testbench.sv
// Self-checking bench for the vertex attribute to binary32 converter.
module testbench;
    import vatf_pkg::*;

    class float_scoreboard;
        logic [2:0]  fmt;
        logic        norm;
        logic [31:0] pending[$];
        int          errors;

        function new();
            fmt = FMT_F32;
            norm = 1'b0;
            errors = 0;
        endfunction

        // round an exactly held (or double-rounded quotient) real to binary32, RNE
        function logic [31:0] to_f32(real r);
            logic [63:0] d;
            logic [52:0] m;
            logic [24:0] keep;
            logic [28:0] rem;
            int          e;
            d = $realtobits(r);
            if (d[62:0] == 63'd0) return {d[63], 31'd0};
            m = {1'b1, d[51:0]};
            e = int'(d[62:52]) - 1023 + 127;
            keep = {1'b0, m[52:29]};
            rem = m[28:0];
            if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && keep[0])) keep = keep + 25'd1;
            if (keep[24]) begin
                keep = keep >> 1;
                e = e + 1;
            end
            return {d[63], e[7:0], keep[22:0]};
        endfunction

        function logic [31:0] convert(logic [31:0] raw);
            real v, dv;
            logic sgn;
            sgn = 1'b0;
            case (fmt)
                FMT_S8:  begin v = real'($signed(raw[7:0]));  dv = 127.0;        sgn = 1'b1; end
                FMT_U8:  begin v = real'(raw[7:0]);           dv = 255.0;        end
                FMT_S16: begin v = real'($signed(raw[15:0])); dv = 32767.0;      sgn = 1'b1; end
                FMT_U16: begin v = real'(raw[15:0]);          dv = 65535.0;      end
                FMT_S32: begin v = real'($signed(raw));       dv = 2147483648.0; sgn = 1'b1; end
                FMT_U32: begin v = real'(raw);                dv = 4294967296.0; end
                default: return raw;
            endcase
            // 32-bit divisors are powers of two, so one rounding at the end suffices
            if (!norm) return to_f32(v);
            v = v / dv;
            if (sgn && v < -1.0) v = -1.0;
            return to_f32(v);
        endfunction

        function void note_word(logic [31:0] raw);
            pending = {pending, convert(raw)};
        endfunction

        function void check_word(logic [31:0] bits);
            logic [31:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, bits);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== bits) begin
                $display("%0t: float_bits mismatch expected %h actual %h", $time, want, bits);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    t_cfg_idx i_cfg_idx = CFG_FORMAT;
    logic [2:0] i_cfg_wdata = 3'd0;
    logic calm = 0;
    int   n_accepted = 0;

    vatf_in_if  in_if();
    vatf_out_if out_if();

    float_scoreboard sb = new();

    vertex_attribute_to_float u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_if.sink), .o_out(out_if.source)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        in_if.valid = 0;
        in_if.raw_component = 0;
        out_if.ready = 0;
    end

    always @(negedge i_clk)
        out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_word(in_if.raw_component);
                n_accepted++;
            end
            if (out_if.valid && out_if.ready) sb.check_word(out_if.float_bits);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [2:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FORMAT) sb.fmt = val;
        else sb.norm = val[0];
    endtask

    // caller sits at a negedge; returns at the negedge after acceptance
    task automatic send_word(logic [31:0] raw);
        int seen;
        while (!calm && $urandom_range(0, 99) < 34) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        seen = n_accepted;
        in_if.valid <= 1'b1;
        in_if.raw_component <= raw;
        @(negedge i_clk);
        while (n_accepted == seen) @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 3);
            1: return $urandom | 32'h0000_0080;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: return 32'h8000_0000 ^ $urandom_range(0, 3);
            4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'(1 << $urandom_range(0, 15))};
            default: return $urandom;
        endcase
    endfunction

    logic [31:0] corners[12] = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'h81, 32'hFF,
                                 32'h7FFF, 32'h8000, 32'hFFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'hFFFF_FFFF};

    initial begin
        int k;
        int timeout;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // reset setting is float pass-through, normalize off
        send_word(32'h7FC0_0001);
        send_word(32'hFF80_0000);
        in_if.valid <= 1'b0;
        drain();
        for (int ph = 0; ph < 16; ph++) begin
            in_if.valid <= 1'b0;
            write_reg(CFG_FORMAT, 3'(ph % 8));
            write_reg(CFG_NORM, 3'(ph / 8));
            calm = (ph == 5 || ph == 13);
            if (ph == 0 || ph == 4 || ph == 12)
                foreach (corners[i]) send_word(corners[i]);
            for (k = 0; k < 50; k++) send_word(pick_word());
            in_if.valid <= 1'b0;
            drain();
        end
        timeout = 0;
        while (sb.pending.size() != 0 && timeout < 1000) begin
            @(negedge i_clk);
            timeout++;
        end
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("vertex_attribute_to_float verification clean");
        else
            $display("vertex_attribute_to_float verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("vertex_attribute_to_float verification failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/vatf_pkg.sv
src/vatf_if.sv
src/vatf_fp_pack.sv
src/vertex_attribute_to_float.sv
dv/testbench.sv
